/* src/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// types and the alphabet function shared by the base64 byte encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       char_last;
	} out_word_t;

	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	// one encoded item: first char, optional second char
	typedef struct packed {
		logic      two;
		out_word_t c0;
		out_word_t c1;
	} enc_res_t;

	localparam logic [6:0] CH_UPPER_A = 7'd65;
	localparam logic [6:0] CH_LOWER_A = 7'd97;
	localparam logic [6:0] CH_ZERO    = 7'd48;
	localparam logic [6:0] CH_PLUS    = 7'd43;
	localparam logic [6:0] CH_SLASH   = 7'd47;

	function automatic logic [6:0] b64_char(input logic [5:0] six);
		logic [6:0] s;
		logic [6:0] r;
		s = {1'b0, six};
		if (six < 6'd26) begin
			r = CH_UPPER_A + s;
		end else if (six < 6'd52) begin
			r = CH_LOWER_A + s - 7'd26;
		end else if (six < 6'd62) begin
			r = CH_ZERO + s - 7'd52;
		end else if (six == 6'd62) begin
			r = CH_PLUS;
		end else begin
			r = CH_SLASH;
		end
		return r;
	endfunction

endpackage

/* src/base64_byte_encoder.sv */
// ----------------------------------------------------------------------------
// base64_byte_encoder
// unpadded base64 encoder: one byte in, one or two alphabet chars out
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | word
//  byte    | in  | byte_valid / byte_stall | b64e_pkg::in_word_t  (data_byte, is_last)
//  char    | out | char_valid / char_stall | b64e_pkg::out_word_t (out_char, char_last)
//
//  one char leaves per cycle while char_stall is low; a two-char byte sends its first char, then its second
//  the single result register sets the pace: a new byte loads only when it is empty or its last char leaves
//  first char is valid once the byte has passed the input register, then the result register
//  arst_n clears the group phase, carry bits and both valid flags
//  byte_stall rises only when the input register is full and cannot move on
// ----------------------------------------------------------------------------
module base64_byte_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64e_pkg::in_word_t  byte_word,
	output logic                char_valid,
	input  logic                char_stall,
	output b64e_pkg::out_word_t char_word
);

	logic               v_s1;
	b64e_pkg::in_word_t word_s1;
	b64e_pkg::enc_res_t res;
	logic               free;
	logic               move;
	logic               accept;

	assign move       = v_s1 && free;
	assign byte_stall = v_s1 && !free;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= byte_word;
		end
	end

	b64e_enc u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (move),
		.word   (word_s1),
		.res    (res)
	);

	b64e_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_en    (move),
		.load       (res),
		.free       (free),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word)
	);

endmodule

/* src/b64e_enc.sv */
// ----------------------------------------------------------------------------
// b64e_enc
// group phase and carry registers, splits one byte into one or two chars
// ----------------------------------------------------------------------------
module b64e_enc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  b64e_pkg::in_word_t word,
	output b64e_pkg::enc_res_t res
);

	b64e_pkg::phase_t phase_q, phase_d;
	logic [3:0]       carry_q, carry_d;
	logic [5:0]       six0, six1;
	logic             two, last1;
	logic [7:0]       b;

	assign b = word.data_byte;

	always_comb begin
		six0    = b[7:2];
		six1    = 6'd0;
		two     = 1'b0;
		last1   = 1'b0;
		phase_d = b64e_pkg::PH_1;
		carry_d = {2'b00, b[1:0]};
		case (phase_q)
			b64e_pkg::PH_1: begin
				six0    = {carry_q[1:0], b[7:4]};
				six1    = {b[3:0], 2'b00};
				two     = word.is_last;
				last1   = 1'b1;
				phase_d = b64e_pkg::PH_2;
				carry_d = b[3:0];
			end
			b64e_pkg::PH_2: begin
				six0    = {carry_q[3:0], b[7:6]};
				six1    = b[5:0];
				two     = 1'b1;
				last1   = word.is_last;
				phase_d = b64e_pkg::PH_0;
				carry_d = 4'd0;
			end
			default: begin
				six0    = b[7:2];
				six1    = {b[1:0], 4'b0000};
				two     = word.is_last;
				last1   = 1'b1;
				phase_d = b64e_pkg::PH_1;
				carry_d = {2'b00, b[1:0]};
			end
		endcase
		if (word.is_last) begin
			phase_d = b64e_pkg::PH_0;
			carry_d = 4'd0;
		end
	end

	assign res.two          = two;
	assign res.c0.out_char  = b64e_pkg::b64_char(six0);
	assign res.c0.char_last = 1'b0;
	assign res.c1.out_char  = b64e_pkg::b64_char(six1);
	assign res.c1.char_last = last1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64e_pkg::PH_0;
			carry_q <= 4'd0;
		end else if (en) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

	// a two-char word from the start of a group only closes the stream
	a_two_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		en && phase_q == b64e_pkg::PH_0 && res.two |-> word.is_last)
		else $error("two chars at group start without last byte");

	// last byte puts the group back at its start
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		en && word.is_last |=> phase_q == b64e_pkg::PH_0 && carry_q == 4'd0)
		else $error("group state not cleared after last byte");

endmodule

/* src/b64e_obuf.sv */
// ----------------------------------------------------------------------------
// b64e_obuf
// result register holding up to two chars, hands them out one per cycle while char_stall is low
// ----------------------------------------------------------------------------
module b64e_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  b64e_pkg::enc_res_t  load,
	output logic                free,
	output logic                char_valid,
	input  logic                char_stall,
	output b64e_pkg::out_word_t char_word
);

	logic                v_q;
	logic                two_q;
	logic                idx_q;
	b64e_pkg::out_word_t c0_q, c1_q;
	logic                pop, drain_done;

	assign pop        = v_q && !char_stall;
	assign drain_done = pop && (!two_q || idx_q);
	assign free       = !v_q || drain_done;
	assign char_valid = v_q;
	assign char_word  = idx_q ? c1_q : c0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			two_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (load_en) begin
			v_q   <= 1'b1;
			two_q <= load.two;
			idx_q <= 1'b0;
		end else if (drain_done) begin
			v_q   <= 1'b0;
			idx_q <= 1'b0;
		end else if (pop) begin
			idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			c0_q <= load.c0;
			c1_q <= load.c1;
		end
	end

	// second char is only pointed at in a two-char word
	a_idx_two: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && idx_q |-> two_q)
		else $error("second char selected in a one-char word");

	// no load over chars not yet handed out
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |-> free)
		else $error("result register overwritten");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the unpadded base64 byte encoder: a directed table
// of byte streams, then random streams under several idle and stall mixes,
// every char word compared against typed table chars or a behavioral encoder model
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_BYTES  = 307;
	localparam logic [0:63][7:0] B64_SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		b64e_pkg::in_word_t w;
		logic [1:0]         typed_n;
		logic [6:0]         c0;
		logic [6:0]         c1;
	} dir_row_t;

	localparam int unsigned N_ROWS = 23;
	localparam dir_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{'{8'h00, 1'b1}, 2'd2, 7'h41, 7'h41},	// "AA"
		'{'{8'hFF, 1'b1}, 2'd2, 7'h2F, 7'h77},	// "/w"
		'{'{8'hFF, 1'b0}, 2'd1, 7'h2F, 7'h00},	// "////"
		'{'{8'hFF, 1'b0}, 2'd1, 7'h2F, 7'h00},
		'{'{8'hFF, 1'b1}, 2'd2, 7'h2F, 7'h2F},
		'{'{8'h00, 1'b0}, 2'd1, 7'h41, 7'h00},	// "AAAA"
		'{'{8'h00, 1'b0}, 2'd1, 7'h41, 7'h00},
		'{'{8'h00, 1'b1}, 2'd2, 7'h41, 7'h41},
		'{'{8'hFF, 1'b0}, 2'd1, 7'h2F, 7'h00},	// "//8"
		'{'{8'hFF, 1'b1}, 2'd2, 7'h2F, 7'h38},
		'{'{8'h4D, 1'b0}, 2'd1, 7'h54, 7'h00},	// "TWFu"
		'{'{8'h61, 1'b0}, 2'd1, 7'h57, 7'h00},
		'{'{8'h6E, 1'b1}, 2'd2, 7'h46, 7'h75},
		'{'{8'hF8, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'h10, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'hAA, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'h55, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'h01, 1'b1}, 2'd0, 7'h00, 7'h00},
		'{'{8'h80, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'h7F, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'hC3, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'h3C, 1'b0}, 2'd0, 7'h00, 7'h00},
		'{'{8'h96, 1'b1}, 2'd0, 7'h00, 7'h00}
	};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	b64e_pkg::in_word_t  byte_word = '0;
	logic                char_valid;
	logic                char_stall = 1'b0;
	b64e_pkg::out_word_t char_word;

	b64e_pkg::phase_t    enc_phase = b64e_pkg::PH_0;
	logic [3:0]          enc_carry = 4'd0;
	b64e_pkg::out_word_t expected_chars [$];
	b64e_pkg::out_word_t oldest_char;
	int unsigned         fail_count = 0;
	int unsigned         quiet_cycles = 0;
	int unsigned         send_idle_pct = 0;
	int unsigned         stall_pct = 0;
	int unsigned         sent_bytes = 0;

	base64_byte_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic b64e_pkg::out_word_t b64_word(input logic [5:0] six, input logic last);
		b64e_pkg::out_word_t r;
		r.out_char  = B64_SYMBOLS[six][6:0];
		r.char_last = last;
		return r;
	endfunction

	// advances the encoder state by one byte, gives its chars in c0 and c1 and returns their number
	function automatic int unsigned encode_byte(input b64e_pkg::in_word_t w,
			output b64e_pkg::out_word_t c0, output b64e_pkg::out_word_t c1);
		logic [5:0] s0;
		logic [5:0] s1;
		logic       two;
		case (enc_phase)
			b64e_pkg::PH_1: begin
				s0        = {enc_carry[1:0], w.data_byte[7:4]};
				s1        = {w.data_byte[3:0], 2'b00};
				two       = w.is_last;
				enc_carry = w.data_byte[3:0];
				enc_phase = b64e_pkg::PH_2;
			end
			b64e_pkg::PH_2: begin
				s0        = {enc_carry, w.data_byte[7:6]};
				s1        = w.data_byte[5:0];
				two       = 1'b1;
				enc_carry = 4'd0;
				enc_phase = b64e_pkg::PH_0;
			end
			default: begin
				s0        = w.data_byte[7:2];
				s1        = {w.data_byte[1:0], 4'b0000};
				two       = w.is_last;
				enc_carry = {2'b00, w.data_byte[1:0]};
				enc_phase = b64e_pkg::PH_1;
			end
		endcase
		if (w.is_last) begin
			enc_phase = b64e_pkg::PH_0;
			enc_carry = 4'd0;
		end
		c0 = b64_word(s0, w.is_last & ~two);
		c1 = b64_word(s1, w.is_last);
		return two ? 2 : 1;
	endfunction

	task automatic send_byte(input b64e_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word  <= w;
		do @(posedge clk); while (byte_stall);
		sent_bytes++;
	endtask

	task automatic send_predicted(input b64e_pkg::in_word_t w);
		b64e_pkg::out_word_t c0;
		b64e_pkg::out_word_t c1;
		int unsigned         n;
		send_byte(w);
		n = encode_byte(w, c0, c1);
		expected_chars.push_back(c0);
		if (n == 2) begin
			expected_chars.push_back(c1);
		end
	endtask

	task automatic send_stream(input int unsigned len);
		b64e_pkg::in_word_t w;
		for (int unsigned k = 0; k < len; k++) begin
			case ($urandom_range(7))
				0: w.data_byte = 8'h00;
				1: w.data_byte = 8'hFF;
				default: w.data_byte = 8'($urandom_range(255));
			endcase
			w.is_last = (k == len - 1);
			send_predicted(w);
		end
	endtask

	task automatic drain_chars();
		byte_valid <= 1'b0;
		do @(posedge clk); while (expected_chars.size() != 0);
	endtask

	// char checker, receiver stall and quiet-cycle count
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected char word: out_char %h char_last %b",
					char_word.out_char, char_word.char_last);
				fail_count++;
			end else begin
				oldest_char = expected_chars.pop_front();
				if (char_word.out_char !== oldest_char.out_char) begin
					$error("out_char: expected %h, actual %h",
						oldest_char.out_char, char_word.out_char);
					fail_count++;
				end
				if (char_word.char_last !== oldest_char.char_last) begin
					$error("char_last: expected %b, actual %b",
						oldest_char.char_last, char_word.char_last);
					fail_count++;
				end
			end
		end
		if (!arst_n || (byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		char_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		b64e_pkg::in_word_t  w;
		b64e_pkg::out_word_t c0;
		b64e_pkg::out_word_t c1;
		int unsigned         send_mix [4];
		int unsigned         stall_mix [4];
		send_mix  = '{0, 49, 0, 37};
		stall_mix = '{0, 0, 49, 37};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			w = DIRECTED_ROWS[i].w;
			if (DIRECTED_ROWS[i].typed_n == 2'd0) begin
				send_predicted(w);
			end else begin
				send_byte(w);
				void'(encode_byte(w, c0, c1));
				expected_chars.push_back(b64e_pkg::out_word_t'{DIRECTED_ROWS[i].c0,
					w.is_last && DIRECTED_ROWS[i].typed_n == 2'd1});
				if (DIRECTED_ROWS[i].typed_n == 2'd2) begin
					expected_chars.push_back(
						b64e_pkg::out_word_t'{DIRECTED_ROWS[i].c1, w.is_last});
				end
			end
		end

		for (int p = 0; p < 4; p++) begin
			drain_chars();
			send_idle_pct = send_mix[p];
			stall_pct     = stall_mix[p];
			sent_bytes    = 0;
			while (sent_bytes < PHASE_BYTES) begin
				case ($urandom_range(19))
					0:       send_stream($urandom_range(10, 40));
					1, 2:    send_stream($urandom_range(10, 20));
					default: send_stream($urandom_range(1, 9));
				endcase
				if ($urandom_range(29) == 0) begin
					drain_chars();
				end
			end
		end

		drain_chars();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$error("%0d char words never arrived", expected_chars.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
